### sv/pdfm_pkg.sv
// Shared constants and types of the PWM duty and frequency meter.
package pdfm_pkg;

  localparam int TS_BITS    = 16;
  localparam int PER_W      = TS_BITS + 1;
  localparam int TICK_W     = 27;
  localparam int DUTY_W     = 7;
  localparam int DIV_W      = TICK_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int OUT_DATA_W = ((DUTY_W + TICK_W + 7) / 8) * 8;

  localparam int unsigned PERCENT = 100;
  localparam logic [TICK_W-1:0] TICK_RATE_RESET = TICK_W'(1000000);

  localparam logic CMD_ARM  = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### sv/pwm_duty_frequency_meter.sv
// PWM duty/frequency meter: edge capture, result sequencer over one shared serial divider.
// Arm commands and edges that do not complete a measurement are taken whenever the sequencer is idle.
// An edge completing a measurement reaches its result through two divisions
// (duty, then frequency) on the one divider, plus setup and output load.
// A zero period skips the divider and goes from the start step straight to the push step.
// rst_n is synchronous, active low: meter idle, tick rate 1000000, no result pending.
module pwm_duty_frequency_meter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pdfm_pkg::TS_BITS-1:0]      in_tdata,   // timestamp
  input  logic [1:0]                        in_tuser,   // cmd, edge_rising
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pdfm_pkg::OUT_DATA_W-1:0]   out_tdata,  // duty_percent, frequency_hz, zero pad
  output logic [0:0]                        out_tuser,  // zero_period
  input  logic                              cfg_wr_en,
  input  logic [pdfm_pkg::TICK_W-1:0]       cfg_wr_data
);
  import pdfm_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_RISE1 = 2'd1;
  localparam logic [1:0] PH_FALL  = 2'd2;
  localparam logic [1:0] PH_RISE2 = 2'd3;

  localparam logic [2:0] SQ_IDLE  = 3'd0;
  localparam logic [2:0] SQ_START = 3'd1;
  localparam logic [2:0] SQ_DUTY  = 3'd2;
  localparam logic [2:0] SQ_FREQ  = 3'd3;
  localparam logic [2:0] SQ_PUSH  = 3'd4;

  logic [1:0]          ph_r, ph_nxt;
  logic [2:0]          sq_r, sq_nxt;
  logic [TICK_W-1:0]   tick_r;
  logic [TS_BITS-1:0]  rise_r, rise_nxt;
  logic [TS_BITS-1:0]  fall_r, fall_nxt;
  logic [TS_BITS-1:0]  high_r, high_nxt;
  logic [PER_W-1:0]    period_r, period_nxt;
  logic [DUTY_W-1:0]   duty_r, duty_nxt;
  logic [TICK_W-1:0]   freq_r, freq_nxt;
  logic                zp_r, zp_nxt;
  logic                ovalid_r, ovalid_nxt;
  logic [DUTY_W-1:0]   odut_r, odut_nxt;
  logic [TICK_W-1:0]   ofrq_r, ofrq_nxt;
  logic                ozp_r, ozp_nxt;

  logic                accept;
  logic                cmd;
  logic                rising;
  logic [TS_BITS-1:0]  high_w;
  logic [TS_BITS-1:0]  low_w;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  pdfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready = (sq_r == SQ_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cmd       = in_tuser[0];
  assign rising    = in_tuser[1];
  assign high_w    = fall_r - rise_r;
  assign low_w     = in_tdata - fall_r;

  always_comb begin
    ph_nxt     = ph_r;
    sq_nxt     = sq_r;
    rise_nxt   = rise_r;
    fall_nxt   = fall_r;
    high_nxt   = high_r;
    period_nxt = period_r;
    duty_nxt   = duty_r;
    freq_nxt   = freq_r;
    zp_nxt     = zp_r;
    ovalid_nxt = ovalid_r;
    odut_nxt   = odut_r;
    ofrq_nxt   = ofrq_r;
    ozp_nxt    = ozp_r;
    div_req    = '0;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    // capture side
    if (accept) begin
      priority if (cmd == CMD_ARM) begin
        ph_nxt = PH_RISE1;
      end else begin
        unique case (ph_r)
          PH_RISE1: if (rising) begin
            rise_nxt = in_tdata;
            ph_nxt   = PH_FALL;
          end
          PH_FALL: if (!rising) begin
            fall_nxt = in_tdata;
            ph_nxt   = PH_RISE2;
          end
          PH_RISE2: if (rising) begin
            ph_nxt     = PH_IDLE;
            high_nxt   = high_w;
            period_nxt = {1'b0, high_w} + {1'b0, low_w};
            sq_nxt     = SQ_START;
          end
          default: ;
        endcase
      end
    end

    // result sequencer
    unique case (sq_r)
      SQ_IDLE: ;
      SQ_START: begin
        if (period_r == '0) begin
          duty_nxt = '0;
          freq_nxt = '0;
          zp_nxt   = 1'b1;
          sq_nxt   = SQ_PUSH;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = DIV_W'(high_r * PERCENT);
          div_req.divisor  = period_r;
          zp_nxt           = 1'b0;
          sq_nxt           = SQ_DUTY;
        end
      end
      SQ_DUTY: if (div_rsp.done) begin
        // high <= period, so the quotient is at most 100
        duty_nxt         = div_rsp.quotient[DUTY_W-1:0];
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(tick_r);
        div_req.divisor  = period_r;
        sq_nxt           = SQ_FREQ;
      end
      SQ_FREQ: if (div_rsp.done) begin
        freq_nxt = div_rsp.quotient[TICK_W-1:0];
        sq_nxt   = SQ_PUSH;
      end
      SQ_PUSH: if (!ovalid_r || out_tready) begin
        ovalid_nxt = 1'b1;
        odut_nxt   = duty_r;
        ofrq_nxt   = freq_r;
        ozp_nxt    = zp_r;
        sq_nxt     = SQ_IDLE;
      end
      default: sq_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_IDLE;
      sq_r     <= SQ_IDLE;
      ovalid_r <= 1'b0;
      tick_r   <= TICK_RATE_RESET;
      rise_r   <= '0;
      fall_r   <= '0;
    end else begin
      ph_r     <= ph_nxt;
      sq_r     <= sq_nxt;
      ovalid_r <= ovalid_nxt;
      rise_r   <= rise_nxt;
      fall_r   <= fall_nxt;
      if (cfg_wr_en) begin
        tick_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    high_r   <= high_nxt;
    period_r <= period_nxt;
    duty_r   <= duty_nxt;
    freq_r   <= freq_nxt;
    zp_r     <= zp_nxt;
    odut_r   <= odut_nxt;
    ofrq_r   <= ofrq_nxt;
    ozp_r    <= ozp_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_DATA_W - DUTY_W - TICK_W){1'b0}}, ofrq_r, odut_r};
  assign out_tuser  = ozp_r;

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ozp_r) |-> (odut_r == '0 && ofrq_r == '0))
    else $error("zero period request carries nonzero fields");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> (odut_r <= DUTY_W'(PERCENT)))
    else $error("duty above 100 percent");

  a_div_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_r == SQ_DUTY || sq_r == SQ_FREQ) |-> (div_rsp.busy || div_rsp.done))
    else $error("sequencer waits on an idle divider");

  a_rose_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(sq_r) == SQ_PUSH)
    else $error("result request raised outside push step");

endmodule

### sv/pdfm_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module pdfm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pdfm_pkg::div_req_t  req,
  output pdfm_pkg::div_rsp_t  rsp
);
  import pdfm_pkg::*;

  logic [DIV_W-1:0]     quo_r;
  logic [PER_W-1:0]     rem_r;
  logic [PER_W-1:0]     dvs_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 done_r;

  logic [PER_W:0]       trial;
  logic [PER_W:0]       diff;
  logic                 qbit;
  logic [PER_W-1:0]     rem_nxt;

  // rem < divisor, so trial < 2*divisor: MSB of diff is the borrow
  assign trial   = {rem_r, quo_r[DIV_W-1]};
  assign diff    = trial - {1'b0, dvs_r};
  assign qbit    = ~diff[PER_W];
  assign rem_nxt = qbit ? diff[PER_W-1:0] : trial[PER_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        cnt_r <= DIV_CNT_W'(DIV_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (cnt_r != '0) begin
      quo_r <= {quo_r[DIV_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign rsp.busy     = (cnt_r != '0);
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !rsp.busy)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !rsp.busy && !$past(req.start))
    else $error("divider done out of sequence");

endmodule
